FILE: sv/deq_pkg.sv
`default_nettype none

package deq_pkg;

    // Fixed field widths of the item channels
    localparam int MODE_W   = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 9;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // Default queue depth
    localparam int DEPTH_DEF = 256;

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        M_PUSH_BACK  = 3'd0,
        M_PUSH_FRONT = 3'd1,
        M_POP_FRONT  = 3'd2,
        M_POP_BACK   = 3'd3,
        M_READ       = 3'd4,
        M_REMOVE     = 3'd5,
        M_CLEAR      = 3'd6
    } mode_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RM_WORD,
        S_SH_WR,
        S_RESULT
    } state_t;

    // Result beat handed from the sequencer to the output register
    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/bounded_deque_with_indexed_access_core.sv
// Bounded deque with indexed access, ring buffer in one single-port-read RAM.
// Flow: an accepted push, pop, read, clear or rejected request passes through the
//   sequencer state register and then the output register; a remove first steps
//   through S_RM_WORD and S_SH_WR, one word per cycle through the RAM ports.
// A new request is taken only once the sequencer has handed the last result to
//   the output register; a remove holds off the next request until its shift ends.
// Reset (rst_n low, async): queue empty, front slot 0; RAM contents kept.
`default_nettype none

module bounded_deque_with_indexed_access_core
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // request channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic signed [WORD_W-1:0] value,
    input  wire logic [POS_W-1:0]         position,
    // result channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [WORD_W-1:0]      word_out,
    output logic [COUNT_W-1:0]            count,
    output logic [STATUS_W-1:0]           status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              in_ready;
    logic              res_valid;
    logic              res_ready;
    res_t              res;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [WORD_W-1:0] mem_rd_data;

    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;
    logic              load;

    deq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .value       (value),
        .position    (position),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    deq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_stall = !in_ready;

    // Output register: takes a new beat when empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign word_out  = out_res_reg.word;
    assign count     = out_res_reg.count;
    assign status    = out_res_reg.status;

endmodule

`default_nettype wire

FILE: sv/deq_mem.sv
`default_nettype none

module deq_mem
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0]      rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/deq_ctrl.sv
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // request side
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic signed [WORD_W-1:0] value,
    input  wire logic [POS_W-1:0]         position,
    // result side
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output res_t                          res,
    // memory port
    output logic                          mem_wr_en,
    output logic [AW-1:0]                 mem_wr_addr,
    output logic [WORD_W-1:0]             mem_wr_data,
    output logic                          mem_rd_en,
    output logic [AW-1:0]                 mem_rd_addr,
    input  wire logic [WORD_W-1:0]        mem_rd_data
);

    localparam int SW = CW + 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    state_t                   state_reg, state_next;
    logic [AW-1:0]            front_reg, front_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic signed [WORD_W-1:0] word_reg, word_next;
    status_t                  status_reg, status_next;

    logic                     full;
    logic                     empty;
    logic                     pos_bad;
    logic [CW-1:0]            pos_m1;
    logic [AW-1:0]            front_dec;

    // Physical slot of the word at offset k from the front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] fp,
                                              input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(fp) + SW'(k);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Request checks
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pos_bad   = (position == '0) || (PW'(position) > PW'(count_reg));
    assign pos_m1    = CW'(position) - CW'(1);
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        word_next   = word_reg;
        status_next = status_reg;

        in_ready    = 1'b0;
        res_valid   = 1'b0;
        res.word    = word_reg;
        res.count   = COUNT_W'(count_reg);
        res.status  = status_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = value;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    status_next = ST_OK;
                    word_next   = '0;
                    state_next  = S_RESULT;
                    case (mode)
                        M_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = slot_of(front_reg, count_reg);
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        M_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = front_dec;
                                front_next  = front_dec;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        M_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = front_reg;
                                front_next  = slot_of(front_reg, CW'(1));
                                count_next  = count_reg - CW'(1);
                                state_next  = S_READ;
                            end
                        end
                        M_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = slot_of(front_reg, count_reg - CW'(1));
                                count_next  = count_reg - CW'(1);
                                state_next  = S_READ;
                            end
                        end
                        M_READ, M_REMOVE:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_bad)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = slot_of(front_reg, pos_m1);
                                idx_next    = pos_m1;
                                state_next  = (mode == M_REMOVE) ? S_RM_WORD : S_READ;
                            end
                        end
                        M_CLEAR:
                        begin
                            front_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused code: no operation
                        end
                    endcase
                end
            end

            // read data of a pop or indexed read goes straight out
            S_READ:
            begin
                res_valid  = 1'b1;
                res.word   = mem_rd_data;
                res.status = ST_OK;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            // keep the removed word, start closing the gap
            S_RM_WORD:
            begin
                word_next = mem_rd_data;
                if (SW'(idx_reg) + SW'(1) < SW'(count_reg))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_of(front_reg, idx_reg + CW'(1));
                    state_next  = S_SH_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESULT;
                end
            end

            // one word moves down per cycle; read runs two slots ahead
            S_SH_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = slot_of(front_reg, idx_reg);
                mem_wr_data = mem_rd_data;
                idx_next    = idx_reg + CW'(1);
                if (SW'(idx_reg) + SW'(2) < SW'(count_reg))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot_of(front_reg, idx_reg + CW'(2));
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count exceeds depth");

    a_no_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
        else $error("read and write hit the same slot");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("pending result changed");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (mode == M_PUSH_BACK || mode == M_PUSH_FRONT) && !full
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow the count");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WR) |-> !in_ready && !res_valid)
        else $error("shift loop overlaps a handshake");

endmodule

`default_nettype wire

FILE: verif/deq_reply_checker.sv
`timescale 1ns / 1ps

module deq_reply_checker
    import deq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [MODE_W-1:0]        mode,
    input  logic signed [WORD_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [WORD_W-1:0] word_out,
    input  logic [COUNT_W-1:0]       count,
    input  logic [STATUS_W-1:0]      status,
    output int                       fails,
    output int                       pending
);

    // Shadow copy of the ring buffer
    logic signed [WORD_W-1:0] ring_words [DEPTH_DEF];
    int   front_slot = 0;
    int   word_count = 0;
    int   mismatch_total = 0;
    int   beat_index = 0;
    res_t awaited_replies [$];

    // Physical slot of the word at a 0-based offset from the front
    function automatic int slot_at(input int offset);
        return (front_slot + offset) % DEPTH_DEF;
    endfunction

    // Apply one request to the shadow deque and return the reply it should give
    function automatic res_t deque_apply(input logic [MODE_W-1:0]        op,
                                         input logic signed [WORD_W-1:0] data,
                                         input logic [POS_W-1:0]         pos);
        res_t reply;
        int   idx;
        reply.word   = '0;
        reply.status = ST_OK;
        case (op)
            M_PUSH_BACK:
                if (word_count >= DEPTH_DEF)
                    reply.status = ST_FULL;
                else
                begin
                    ring_words[slot_at(word_count)] = data;
                    word_count++;
                end
            M_PUSH_FRONT:
                if (word_count >= DEPTH_DEF)
                    reply.status = ST_FULL;
                else
                begin
                    front_slot = (front_slot == 0) ? DEPTH_DEF - 1 : front_slot - 1;
                    ring_words[front_slot] = data;
                    word_count++;
                end
            M_POP_FRONT:
                if (word_count == 0)
                    reply.status = ST_EMPTY;
                else
                begin
                    reply.word = ring_words[front_slot];
                    front_slot = slot_at(1);
                    word_count--;
                end
            M_POP_BACK:
                if (word_count == 0)
                    reply.status = ST_EMPTY;
                else
                begin
                    reply.word = ring_words[slot_at(word_count - 1)];
                    word_count--;
                end
            M_READ, M_REMOVE:
                if (word_count == 0)
                    reply.status = ST_EMPTY;
                else if (pos == 0 || int'(pos) > word_count)
                    reply.status = ST_RANGE;
                else
                begin
                    reply.word = ring_words[slot_at(int'(pos) - 1)];
                    // later words close up toward the front
                    if (op == M_REMOVE)
                    begin
                        for (idx = int'(pos) - 1; idx + 1 < word_count; idx++)
                            ring_words[slot_at(idx)] = ring_words[slot_at(idx + 1)];
                        word_count--;
                    end
                end
            M_CLEAR:
            begin
                word_count = 0;
                front_slot = 0;
            end
            default:
                ;
        endcase
        reply.count = COUNT_W'(word_count);
        return reply;
    endfunction

    // One line per mismatch
    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
        $display("deq_reply_checker: beat %0d %s: got %0h, expected %0h",
                 beat_index, what, got, want);
        mismatch_total++;
    endtask

    // Compare result beats first, then queue the reply for a new request beat
    always @(posedge clk)
    begin
        res_t want;
        if (!rst_n)
        begin
            front_slot = 0;
            word_count = 0;
            awaited_replies.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_replies.size() == 0)
                    flag_mismatch("unexpected beat", word_out, '0);
                else
                begin
                    want = awaited_replies.pop_front();
                    if (word_out !== want.word)
                        flag_mismatch("word_out", word_out, want.word);
                    if (count !== want.count)
                        flag_mismatch("count", WORD_W'(count), WORD_W'(want.count));
                    if (status !== want.status)
                        flag_mismatch("status", WORD_W'(status), WORD_W'(want.status));
                end
                beat_index++;
            end
            if (in_valid && !in_stall)
                awaited_replies.push_back(deque_apply(mode, value, position));
        end
        fails   <= mismatch_total;
        pending <= awaited_replies.size();
    end

endmodule

FILE: verif/bounded_deque_with_indexed_access_core_test.sv
`timescale 1ns / 1ps

module bounded_deque_with_indexed_access_core_test
    import deq_pkg::*;
();

    localparam int                STALL_LIMIT  = 2000;
    localparam int                DRAIN_CYCLES = 20;
    localparam logic [MODE_W-1:0] M_SPARE      = 3'd7;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [MODE_W-1:0]        mode      = '0;
    logic signed [WORD_W-1:0] value     = '0;
    logic [POS_W-1:0]         position  = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [WORD_W-1:0] word_out;
    logic [COUNT_W-1:0]       count;
    logic [STATUS_W-1:0]      status;

    int fails;
    int pending;
    int depth_est    = 0;
    int quiet_cycles = 0;
    bit no_idle      = 1'b0;

    always #1 clk = ~clk;

    bounded_deque_with_indexed_access_core #(
        .DEPTH(DEPTH_DEF)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .value    (value),
        .position (position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .word_out (word_out),
        .count    (count),
        .status   (status)
    );

    deq_reply_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .value    (value),
        .position (position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .word_out (word_out),
        .count    (count),
        .status   (status),
        .fails    (fails),
        .pending  (pending)
    );

    // Watchdog: too long without any beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("bounded_deque_with_indexed_access_core_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stall before taking each beat, none in no-idle stretches
    initial
    begin
        int hold;
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 3);
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Drive one request beat after a random gap and wait until it is taken
    task automatic send_request(input logic [MODE_W-1:0]        op,
                                input logic signed [WORD_W-1:0] data,
                                input logic [POS_W-1:0]         pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = op;
        value    = data;
        position = pos;
        do @(posedge clk); while (in_stall);
        // rough occupancy, only used to aim positions and phases
        case (op)
            M_PUSH_BACK, M_PUSH_FRONT:
                if (depth_est < DEPTH_DEF)
                    depth_est++;
            M_POP_FRONT, M_POP_BACK:
                if (depth_est > 0)
                    depth_est--;
            M_REMOVE:
                if (pos != 0 && int'(pos) <= depth_est)
                    depth_est--;
            M_CLEAR:
                depth_est = 0;
            default:
                ;
        endcase
    endtask

    // Mostly valid positions, some just past the end, zero, or anything
    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(0, 9);
        if (depth_est > 0 && roll < 7)
            return POS_W'($urandom_range(1, depth_est));
        if (roll == 7)
            return POS_W'(depth_est + 1);
        if (roll == 8)
            return '0;
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    // Random request with a given share of pushes
    task automatic random_request(input int push_pct);
        int                roll;
        logic [MODE_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            op = $urandom_range(0, 1) ? M_PUSH_BACK : M_PUSH_FRONT;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                op = M_POP_FRONT;
            else if (roll < 45)
                op = M_POP_BACK;
            else if (roll < 70)
                op = M_READ;
            else if (roll < 92)
                op = M_REMOVE;
            else if (roll < 96)
                op = M_CLEAR;
            else
                op = M_SPARE;
        end
        send_request(op, $urandom, pick_position());
    endtask

    initial
    begin
        int n;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty cases, extreme words and positions, every mode
        send_request(M_POP_FRONT, 0, 0);
        send_request(M_POP_BACK, 0, 0);
        send_request(M_READ, 0, 1);
        send_request(M_REMOVE, 0, 0);
        send_request(M_PUSH_BACK, 32'sh7fffffff, 0);
        send_request(M_PUSH_FRONT, 32'sh80000000, 9'h1ff);
        send_request(M_PUSH_BACK, -1, 0);
        send_request(M_PUSH_FRONT, 0, 0);
        send_request(M_READ, 0, 0);
        send_request(M_READ, 0, 9'h1ff);
        send_request(M_READ, 0, 4);
        send_request(M_READ, 0, 5);
        send_request(M_READ, 0, 9'd256);
        send_request(M_REMOVE, 0, 2);
        send_request(M_REMOVE, 0, 3);
        send_request(M_REMOVE, 0, 0);
        send_request(M_POP_FRONT, 0, 0);
        send_request(M_POP_BACK, 0, 0);
        send_request(M_PUSH_BACK, $urandom, 0);
        send_request(M_SPARE, $urandom, 9'h1ff);
        send_request(M_CLEAR, $urandom, 0);
        send_request(M_POP_FRONT, 0, 0);

        // Mixed traffic around a small queue, with a no-idle stretch now and then
        for (n = 0; n < 60; n++)
        begin
            no_idle = (n % 40) >= 30;
            random_request(55);
        end
        no_idle = 1'b0;

        // Fill to full, the first 128 pushes back to back
        n = 0;
        while (depth_est < DEPTH_DEF)
        begin
            no_idle = n < 128;
            random_request(100);
            n++;
        end
        no_idle = 1'b0;

        // Full queue: dropped pushes, last position, longest shift
        send_request(M_PUSH_BACK, $urandom, 0);
        send_request(M_PUSH_FRONT, $urandom, 0);
        send_request(M_READ, 0, 9'd256);
        send_request(M_READ, 0, 9'd257);
        send_request(M_REMOVE, 0, 1);
        send_request(M_REMOVE, 0, POS_W'(depth_est));
        send_request(M_PUSH_FRONT, $urandom, 0);
        send_request(M_PUSH_BACK, $urandom, 0);
        send_request(M_PUSH_BACK, $urandom, 0);

        // Partial drain from a deep queue, then clear
        for (n = 0; n < 40; n++)
            random_request(10);
        send_request(M_CLEAR, 0, 0);
        send_request(M_POP_BACK, 0, 0);

        // Mixed traffic again
        for (n = 0; n < 40; n++)
        begin
            no_idle = (n % 40) >= 30;
            random_request(50);
        end
        no_idle = 1'b0;

        @(negedge clk);
        in_valid = 1'b0;

        // Wait for every reply, then a short tail for stray beats
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fails == 0)
            $display("bounded_deque_with_indexed_access_core_test: PASS");
        else
            $display("bounded_deque_with_indexed_access_core_test: FAIL");
        $finish;
    end

endmodule

FILE: bounded_deque_with_indexed_access_core.f
sv/deq_pkg.sv
sv/deq_mem.sv
sv/deq_ctrl.sv
sv/bounded_deque_with_indexed_access_core.sv
verif/deq_reply_checker.sv
verif/bounded_deque_with_indexed_access_core_test.sv
